/* design/swdhpe_pkg.sv */
// swdhpe_pkg: shared types and constants for the serial wire debug host packet engine
// used by swdhpe_seq and swd_host_packet_engine_unit; no dependencies

package swdhpe_pkg;

  // tick function codes
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_XFER = 2'd1;
  localparam logic [1:0] FUNC_LRST = 2'd2;

  // fixed header bits: start (bit 0) and park (bit 7)
  localparam logic [7:0]  HDR_FIXED = 8'h81;
  localparam logic [2:0]  ACK_OK    = 3'b001;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [4:0]  LAST_BIT  = 5'd31;
  localparam logic [2:0]  HDR_LAST  = 3'd7;
  localparam logic [1:0]  ACK_LAST  = 2'd2;

  // sequencer phase, one-hot
  typedef enum logic [11:0] {
    PH_IDLE  = 12'b0000_0000_0001,
    PH_HDR   = 12'b0000_0000_0010,
    PH_TRN1  = 12'b0000_0000_0100,
    PH_ACK   = 12'b0000_0000_1000,
    PH_RDATA = 12'b0000_0001_0000,
    PH_RPAR  = 12'b0000_0010_0000,
    PH_RTRN  = 12'b0000_0100_0000,
    PH_WTRN  = 12'b0000_1000_0000,
    PH_WDATA = 12'b0001_0000_0000,
    PH_WPAR  = 12'b0010_0000_0000,
    PH_LRHI  = 12'b0100_0000_0000,
    PH_LRLO  = 12'b1000_0000_0000
  } phase_t;

  // one result word
  typedef struct packed {
    logic        clock_pulse;
    logic        swdio_out;
    logic        swdio_drive;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  ack_code;
    logic [31:0] read_data;
    logic        parity_error;
  } res_t;

endpackage

/* design/swdhpe_seq.sv */
// swdhpe_seq: per-tick transfer sequencer, state registers and result logic
// depends on swdhpe_pkg

module swdhpe_seq #(
  parameter int RESET_HIGH_CYCLES = 60,
  parameter int IDLE_LOW_CYCLES   = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [1:0]         func,
  input  logic               ap_not_dp,
  input  logic               read_not_write,
  input  logic [1:0]         reg_addr,
  input  logic [31:0]        write_data,
  input  logic               ignore_ack,
  input  logic               swdio_in,
  output swdhpe_pkg::res_t   res
);

  localparam int CNT_MAX = (RESET_HIGH_CYCLES > IDLE_LOW_CYCLES) ?
                           RESET_HIGH_CYCLES : IDLE_LOW_CYCLES;
  localparam int CNT_W   = (CNT_MAX > 32) ? $clog2(CNT_MAX) : 5;
  localparam logic [CNT_W-1:0] LRHI_LAST = CNT_W'(RESET_HIGH_CYCLES - 1);
  localparam logic [CNT_W-1:0] LRLO_LAST = CNT_W'(IDLE_LOW_CYCLES - 1);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  swdhpe_pkg::phase_t phase_r, phase_nxt, ph;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt;
  logic [31:0]      shift_r, shift_nxt, sw;
  logic [7:0]       hdr_r, hdr_nxt, hdr;
  logic [2:0]       ack_r, ack_nxt, ack;
  logic             par_r, par_nxt, par;
  logic             rd_r, rd_nxt, srd;
  logic             ign_r, ign_nxt, sig;
  logic [3:0]       req;

  assign req = {reg_addr, read_not_write, ap_not_dp};

  // start of operation, then one tick of the sequence
  always_comb begin
    ph  = phase_r;
    cnt = cnt_r;
    sw  = shift_r;
    hdr = hdr_r;
    ack = ack_r;
    par = par_r;
    srd = rd_r;
    sig = ign_r;
    if (phase_r == swdhpe_pkg::PH_IDLE) begin
      if (func == swdhpe_pkg::FUNC_XFER) begin
        hdr = swdhpe_pkg::HDR_FIXED | {2'b00, ^req, req, 1'b0};
        sw  = read_not_write ? 32'd0 : write_data;
        srd = read_not_write;
        sig = ignore_ack;
        ack = 3'd0;
        par = 1'b0;
        cnt = '0;
        ph  = swdhpe_pkg::PH_HDR;
      end else if (func == swdhpe_pkg::FUNC_LRST) begin
        cnt = '0;
        ph  = swdhpe_pkg::PH_LRHI;
      end
    end

    res             = '0;
    res.clock_pulse = 1'b1;
    res.swdio_drive = 1'b1;
    res.busy_res    = 1'b1;
    phase_nxt = ph;
    cnt_nxt   = cnt;
    shift_nxt = sw;
    hdr_nxt   = hdr;
    ack_nxt   = ack;
    par_nxt   = par;
    rd_nxt    = srd;
    ign_nxt   = sig;

    case (ph)
      swdhpe_pkg::PH_HDR: begin
        res.swdio_out = hdr[cnt[2:0]];
        if (cnt[2:0] == swdhpe_pkg::HDR_LAST) begin
          cnt_nxt   = '0;
          phase_nxt = swdhpe_pkg::PH_TRN1;
        end else begin
          cnt_nxt = cnt + CNT_ONE;
        end
      end
      swdhpe_pkg::PH_TRN1: begin
        res.swdio_drive = 1'b0;
        cnt_nxt         = '0;
        phase_nxt       = swdhpe_pkg::PH_ACK;
      end
      swdhpe_pkg::PH_ACK: begin
        res.swdio_drive = 1'b0;
        ack_nxt = ack | (3'(swdio_in) << cnt[1:0]);
        if (cnt[1:0] == swdhpe_pkg::ACK_LAST) begin
          cnt_nxt = '0;
          if (srd) begin
            phase_nxt = (ack_nxt == swdhpe_pkg::ACK_OK) ? swdhpe_pkg::PH_RDATA
                                                         : swdhpe_pkg::PH_RTRN;
          end else begin
            phase_nxt = swdhpe_pkg::PH_WTRN;
          end
        end else begin
          cnt_nxt = cnt + CNT_ONE;
        end
      end
      swdhpe_pkg::PH_RDATA: begin
        res.swdio_drive = 1'b0;
        shift_nxt = sw | (32'(swdio_in) << cnt[4:0]);
        par_nxt   = par ^ swdio_in;
        if (cnt[4:0] == swdhpe_pkg::LAST_BIT) begin
          cnt_nxt   = '0;
          phase_nxt = swdhpe_pkg::PH_RPAR;
        end else begin
          cnt_nxt = cnt + CNT_ONE;
        end
      end
      swdhpe_pkg::PH_RPAR: begin
        res.swdio_drive = 1'b0;
        par_nxt         = par ^ swdio_in;
        phase_nxt       = swdhpe_pkg::PH_RTRN;
      end
      swdhpe_pkg::PH_RTRN: begin
        res.swdio_drive  = 1'b0;
        res.done_res     = 1'b1;
        res.ack_code     = ack;
        res.read_data    = (ack == swdhpe_pkg::ACK_OK) ? sw : swdhpe_pkg::ALL_ONES;
        res.parity_error = (ack == swdhpe_pkg::ACK_OK) ? par : 1'b0;
        phase_nxt        = swdhpe_pkg::PH_IDLE;
      end
      swdhpe_pkg::PH_WTRN: begin
        res.swdio_drive = 1'b0;
        cnt_nxt         = '0;
        // bad acknowledge ends the write unless forced
        if (!sig && ack != swdhpe_pkg::ACK_OK) begin
          res.done_res = 1'b1;
          res.ack_code = ack;
          phase_nxt    = swdhpe_pkg::PH_IDLE;
        end else begin
          phase_nxt = swdhpe_pkg::PH_WDATA;
        end
      end
      swdhpe_pkg::PH_WDATA: begin
        res.swdio_out = sw[cnt[4:0]];
        par_nxt       = par ^ sw[cnt[4:0]];
        if (cnt[4:0] == swdhpe_pkg::LAST_BIT) begin
          cnt_nxt   = '0;
          phase_nxt = swdhpe_pkg::PH_WPAR;
        end else begin
          cnt_nxt = cnt + CNT_ONE;
        end
      end
      swdhpe_pkg::PH_WPAR: begin
        res.swdio_out = par;
        res.done_res  = 1'b1;
        res.ack_code  = ack;
        phase_nxt     = swdhpe_pkg::PH_IDLE;
      end
      swdhpe_pkg::PH_LRHI: begin
        res.swdio_out = 1'b1;
        if (cnt == LRHI_LAST) begin
          cnt_nxt   = '0;
          phase_nxt = swdhpe_pkg::PH_LRLO;
        end else begin
          cnt_nxt = cnt + CNT_ONE;
        end
      end
      swdhpe_pkg::PH_LRLO: begin
        if (cnt == LRLO_LAST) begin
          cnt_nxt      = '0;
          res.done_res = 1'b1;
          phase_nxt    = swdhpe_pkg::PH_IDLE;
        end else begin
          cnt_nxt = cnt + CNT_ONE;
        end
      end
      default: begin
        res.clock_pulse = 1'b0;
        res.busy_res    = 1'b0;
        phase_nxt       = swdhpe_pkg::PH_IDLE;
      end
    endcase
  end

  // state registers, advance once per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= swdhpe_pkg::PH_IDLE;
      cnt_r   <= '0;
      shift_r <= '0;
      hdr_r   <= '0;
      ack_r   <= '0;
      par_r   <= 1'b0;
      rd_r    <= 1'b0;
      ign_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      shift_r <= shift_nxt;
      hdr_r   <= hdr_nxt;
      ack_r   <= ack_nxt;
      par_r   <= par_nxt;
      rd_r    <= rd_nxt;
      ign_r   <= ign_nxt;
    end
  end

  // checks
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.done_res |=> phase_r == swdhpe_pkg::PH_IDLE)
    else $error("phase not idle after done");

  a_perr_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    res.parity_error |-> res.done_res && rd_r)
    else $error("parity error outside read completion");

  a_released_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    !res.swdio_drive |-> !res.swdio_out && res.busy_res)
    else $error("line released while idle or driving a level");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !res.busy_res |-> !res.clock_pulse && !res.done_res)
    else $error("pulse or done while idle");

endmodule

/* design/swd_host_packet_engine_unit.sv */
// swd_host_packet_engine_unit: top level, word handshake and result register
// depends on swdhpe_pkg and swdhpe_seq
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_ready  func, ap_not_dp, read_not_write, reg_addr,
//                                            write_data, ignore_ack, swdio_in
//   out_     output     out_valid/out_ready  clock_pulse, swdio_out, swdio_drive, busy_res,
//                                            done_res, ack_code, read_data, parity_error
//
// one input word per cycle while in_ready is high; its result enters the output register the next cycle
// one tick of the sequencer per accepted word
// a stalled output holds its word; in_ready is low only while that word waits
// synchronous active-low reset returns the sequencer to idle and empties the output

module swd_host_packet_engine_unit #(
  parameter int RESET_HIGH_CYCLES = 60,
  parameter int IDLE_LOW_CYCLES   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic        in_ap_not_dp,
  input  logic        in_read_not_write,
  input  logic [1:0]  in_reg_addr,
  input  logic [31:0] in_write_data,
  input  logic        in_ignore_ack,
  input  logic        in_swdio_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_clock_pulse,
  output logic        out_swdio_out,
  output logic        out_swdio_drive,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [2:0]  out_ack_code,
  output logic [31:0] out_read_data,
  output logic        out_parity_error
);

  logic             accept;
  logic             valid_r, valid_nxt;
  swdhpe_pkg::res_t res;
  swdhpe_pkg::res_t res_r;

  assign in_ready = !valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  swdhpe_seq #(
    .RESET_HIGH_CYCLES (RESET_HIGH_CYCLES),
    .IDLE_LOW_CYCLES   (IDLE_LOW_CYCLES)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (accept),
    .func           (in_func),
    .ap_not_dp      (in_ap_not_dp),
    .read_not_write (in_read_not_write),
    .reg_addr       (in_reg_addr),
    .write_data     (in_write_data),
    .ignore_ack     (in_ignore_ack),
    .swdio_in       (in_swdio_in),
    .res            (res)
  );

  // output word valid
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid        = valid_r;
  assign out_clock_pulse  = res_r.clock_pulse;
  assign out_swdio_out    = res_r.swdio_out;
  assign out_swdio_drive  = res_r.swdio_drive;
  assign out_busy_res     = res_r.busy_res;
  assign out_done_res     = res_r.done_res;
  assign out_ack_code     = res_r.ack_code;
  assign out_read_data    = res_r.read_data;
  assign out_parity_error = res_r.parity_error;

  // checks
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> valid_r)
    else $error("accepted word produced no result");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |-> !accept)
    else $error("input taken while result stalled");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |=> $stable(res_r))
    else $error("stalled result changed");

endmodule

/* tb/sv/swd_host_packet_engine_unit_tb.sv */
// swd_host_packet_engine_unit_tb: self-checking bench for the swd host packet engine
// drives serial-clock tick words, predicts each result word and checks it in order
// depends on swdhpe_pkg and swd_host_packet_engine_unit

`timescale 1ns / 1ps

module swd_host_packet_engine_unit_tb;

  localparam int RESET_HIGH_CYCLES = 60;
  localparam int IDLE_LOW_CYCLES   = 4;
  localparam int RANDOM_TICKS      = 720;

  // the func value with no meaning, behaves as a plain tick
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // acknowledge codes other than ok
  localparam logic [2:0] ACK_WAIT  = 3'b010;
  localparam logic [2:0] ACK_FAULT = 3'b100;
  localparam logic [2:0] ACK_NONE  = 3'b111;
  localparam logic [2:0] ACK_ZERO  = 3'b000;

  // receiver stall modes
  localparam int RX_OPEN    = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_PATTERN = 2;

  // one input word
  typedef struct packed {
    logic [1:0]  func;
    logic        ap_not_dp;
    logic        read_not_write;
    logic [1:0]  reg_addr;
    logic [31:0] write_data;
    logic        ignore_ack;
    logic        swdio_in;
  } tick_word_t;

  // tracks the engine state per tick and holds the result words still owed
  class swd_tick_scoreboard;
    swdhpe_pkg::phase_t phase     = swdhpe_pkg::PH_IDLE;
    logic [5:0]  bit_count    = '0;
    logic [31:0] shift_word   = '0;
    logic [7:0]  header_byte  = '0;
    logic [2:0]  ack_bits     = '0;
    logic        parity_acc   = 1'b0;
    logic        saved_read   = 1'b0;
    logic        saved_ignore = 1'b0;
    swdhpe_pkg::res_t owed_results[$];
    int          errors       = 0;

    task report(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endtask

    function int pending();
      return owed_results.size();
    endfunction

    // one tick of the engine: update state, return the result word
    function swdhpe_pkg::res_t predict_tick(input tick_word_t t);
      swdhpe_pkg::res_t r;
      logic [3:0]       req;
      r = '0;
      r.clock_pulse = 1'b1;
      r.swdio_drive = 1'b1;
      r.busy_res    = 1'b1;
      // start decode while idle
      if (phase == swdhpe_pkg::PH_IDLE) begin
        if (t.func == swdhpe_pkg::FUNC_XFER) begin
          req          = {t.reg_addr, t.read_not_write, t.ap_not_dp};
          header_byte  = swdhpe_pkg::HDR_FIXED | {2'b00, ^req, req, 1'b0};
          shift_word   = t.read_not_write ? 32'd0 : t.write_data;
          saved_read   = t.read_not_write;
          saved_ignore = t.ignore_ack;
          ack_bits     = '0;
          parity_acc   = 1'b0;
          bit_count    = '0;
          phase        = swdhpe_pkg::PH_HDR;
        end else if (t.func == swdhpe_pkg::FUNC_LRST) begin
          bit_count = '0;
          phase     = swdhpe_pkg::PH_LRHI;
        end
      end
      // this tick's bit
      case (phase)
        swdhpe_pkg::PH_HDR: begin
          r.swdio_out = header_byte[bit_count[2:0]];
          if (bit_count >= 6'(swdhpe_pkg::HDR_LAST)) begin
            bit_count = '0;
            phase     = swdhpe_pkg::PH_TRN1;
          end else bit_count++;
        end
        swdhpe_pkg::PH_TRN1: begin
          r.swdio_drive = 1'b0;
          bit_count     = '0;
          phase         = swdhpe_pkg::PH_ACK;
        end
        swdhpe_pkg::PH_ACK: begin
          r.swdio_drive = 1'b0;
          ack_bits      = ack_bits | (3'(t.swdio_in) << bit_count[1:0]);
          if (bit_count >= 6'(swdhpe_pkg::ACK_LAST)) begin
            bit_count = '0;
            if (saved_read) begin
              phase = (ack_bits == swdhpe_pkg::ACK_OK) ? swdhpe_pkg::PH_RDATA
                                                       : swdhpe_pkg::PH_RTRN;
            end else phase = swdhpe_pkg::PH_WTRN;
          end else bit_count++;
        end
        swdhpe_pkg::PH_RDATA: begin
          r.swdio_drive = 1'b0;
          shift_word    = shift_word | (32'(t.swdio_in) << bit_count[4:0]);
          parity_acc    = parity_acc ^ t.swdio_in;
          if (bit_count >= 6'(swdhpe_pkg::LAST_BIT)) begin
            bit_count = '0;
            phase     = swdhpe_pkg::PH_RPAR;
          end else bit_count++;
        end
        swdhpe_pkg::PH_RPAR: begin
          r.swdio_drive = 1'b0;
          parity_acc    = parity_acc ^ t.swdio_in;
          phase         = swdhpe_pkg::PH_RTRN;
        end
        swdhpe_pkg::PH_RTRN: begin
          r.swdio_drive  = 1'b0;
          r.done_res     = 1'b1;
          r.ack_code     = ack_bits;
          r.read_data    = (ack_bits == swdhpe_pkg::ACK_OK) ? shift_word
                                                            : swdhpe_pkg::ALL_ONES;
          r.parity_error = (ack_bits == swdhpe_pkg::ACK_OK) ? parity_acc : 1'b0;
          phase          = swdhpe_pkg::PH_IDLE;
        end
        swdhpe_pkg::PH_WTRN: begin
          r.swdio_drive = 1'b0;
          bit_count     = '0;
          // bad acknowledge without override ends the write here
          if (!saved_ignore && ack_bits != swdhpe_pkg::ACK_OK) begin
            r.done_res = 1'b1;
            r.ack_code = ack_bits;
            phase      = swdhpe_pkg::PH_IDLE;
          end else phase = swdhpe_pkg::PH_WDATA;
        end
        swdhpe_pkg::PH_WDATA: begin
          r.swdio_out = shift_word[bit_count[4:0]];
          parity_acc  = parity_acc ^ r.swdio_out;
          if (bit_count >= 6'(swdhpe_pkg::LAST_BIT)) begin
            bit_count = '0;
            phase     = swdhpe_pkg::PH_WPAR;
          end else bit_count++;
        end
        swdhpe_pkg::PH_WPAR: begin
          r.swdio_out = parity_acc;
          r.done_res  = 1'b1;
          r.ack_code  = ack_bits;
          phase       = swdhpe_pkg::PH_IDLE;
        end
        swdhpe_pkg::PH_LRHI: begin
          r.swdio_out = 1'b1;
          if (int'(bit_count) + 1 >= RESET_HIGH_CYCLES) begin
            bit_count = '0;
            phase     = swdhpe_pkg::PH_LRLO;
          end else bit_count++;
        end
        swdhpe_pkg::PH_LRLO: begin
          if (int'(bit_count) + 1 >= IDLE_LOW_CYCLES) begin
            bit_count  = '0;
            r.done_res = 1'b1;
            phase      = swdhpe_pkg::PH_IDLE;
          end else bit_count++;
        end
        default: begin
          r.clock_pulse = 1'b0;
          r.busy_res    = 1'b0;
          phase         = swdhpe_pkg::PH_IDLE;
        end
      endcase
      return r;
    endfunction

    // accepted input word: queue its result
    function void note_tick(input tick_word_t t);
      owed_results.push_back(predict_tick(t));
    endfunction

    task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // accepted result word: compare with the oldest owed one
    task check_tick(input swdhpe_pkg::res_t got);
      swdhpe_pkg::res_t want;
      if (owed_results.size() == 0) begin
        report("result word with nothing owed");
      end else begin
        want = owed_results.pop_front();
        check_field("clock_pulse", 32'(got.clock_pulse), 32'(want.clock_pulse));
        check_field("swdio_out", 32'(got.swdio_out), 32'(want.swdio_out));
        check_field("swdio_drive", 32'(got.swdio_drive), 32'(want.swdio_drive));
        check_field("busy_res", 32'(got.busy_res), 32'(want.busy_res));
        check_field("done_res", 32'(got.done_res), 32'(want.done_res));
        check_field("ack_code", 32'(got.ack_code), 32'(want.ack_code));
        check_field("read_data", got.read_data, want.read_data);
        check_field("parity_error", 32'(got.parity_error), 32'(want.parity_error));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  tick_word_t  drv_tick;
  logic        out_valid;
  logic        out_ready;
  logic        out_clock_pulse;
  logic        out_swdio_out;
  logic        out_swdio_drive;
  logic        out_busy_res;
  logic        out_done_res;
  logic [2:0]  out_ack_code;
  logic [31:0] out_read_data;
  logic        out_parity_error;
  swdhpe_pkg::res_t got_res;

  swd_tick_scoreboard sb;
  int burst_left;
  int tick_count;
  int stall_left;
  int stall_mode;
  int pat_cnt;

  swd_host_packet_engine_unit #(
    .RESET_HIGH_CYCLES(RESET_HIGH_CYCLES),
    .IDLE_LOW_CYCLES  (IDLE_LOW_CYCLES)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (drv_tick.func),
    .in_ap_not_dp     (drv_tick.ap_not_dp),
    .in_read_not_write(drv_tick.read_not_write),
    .in_reg_addr      (drv_tick.reg_addr),
    .in_write_data    (drv_tick.write_data),
    .in_ignore_ack    (drv_tick.ignore_ack),
    .in_swdio_in      (drv_tick.swdio_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_clock_pulse  (out_clock_pulse),
    .out_swdio_out    (out_swdio_out),
    .out_swdio_drive  (out_swdio_drive),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_ack_code     (out_ack_code),
    .out_read_data    (out_read_data),
    .out_parity_error (out_parity_error)
  );

  // result word as seen on the ports
  assign got_res = {out_clock_pulse, out_swdio_out, out_swdio_drive, out_busy_res,
                    out_done_res, out_ack_code, out_read_data, out_parity_error};

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    #400000;
    $display("swd_host_packet_engine_unit regression: fail");
    $finish;
  end

  // input monitor feeds the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_tick(drv_tick);
  end

  // output monitor checks each accepted word
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_tick(got_res);
  end

  // receiver stalls: open, random or a fixed pattern, in stretches
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(RX_OPEN, RX_PATTERN);
      stall_left = $urandom_range(10, 80);
    end
    stall_left--;
    pat_cnt++;
    case (stall_mode)
      RX_OPEN:   out_ready = 1'b1;
      RX_RANDOM: out_ready = ($urandom_range(0, 99) < 65);
      default:   out_ready = (pat_cnt % 4 != 3);
    endcase
  end

  // send one word; called and returns at a falling edge
  task automatic send_tick(input tick_word_t t);
    int gap;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      gap = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 14);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    drv_tick = t;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    tick_count++;
    @(negedge clk);
  endtask

  // hold off the sender until every owed result word has come
  task automatic drain_results();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // one operation: the starting word, then ticks until the engine is idle again;
  // busy ticks carry random func and fields, which the engine must ignore
  task automatic run_op(input logic [1:0] f, input logic ap, input logic rnw,
                        input logic [1:0] addr, input logic [31:0] wdata, input logic ign,
                        input logic [2:0] ack, input logic [31:0] rword,
                        input logic par_flip);
    tick_word_t t;
    t.func           = f;
    t.ap_not_dp      = ap;
    t.read_not_write = rnw;
    t.reg_addr       = addr;
    t.write_data     = wdata;
    t.ignore_ack     = ign;
    t.swdio_in       = 1'($urandom_range(0, 1));
    send_tick(t);
    while (sb.phase != swdhpe_pkg::PH_IDLE) begin
      t.func           = 2'($urandom_range(0, 3));
      t.ap_not_dp      = 1'($urandom_range(0, 1));
      t.read_not_write = 1'($urandom_range(0, 1));
      t.reg_addr       = 2'($urandom_range(0, 3));
      t.write_data     = $urandom;
      t.ignore_ack     = 1'($urandom_range(0, 1));
      // target side of the line
      case (sb.phase)
        swdhpe_pkg::PH_ACK:   t.swdio_in = ack[sb.bit_count[1:0]];
        swdhpe_pkg::PH_RDATA: t.swdio_in = rword[sb.bit_count[4:0]];
        swdhpe_pkg::PH_RPAR:  t.swdio_in = ^rword ^ par_flip;
        default:              t.swdio_in = 1'($urandom_range(0, 1));
      endcase
      send_tick(t);
    end
  endtask

  // main sequence
  initial begin
    int          r;
    int          random_end;
    bit          paused;
    logic [1:0]  f;
    logic [2:0]  ack;
    sb         = new();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    drv_tick   = '0;
    out_ready  = 1'b0;
    burst_left = 0;
    tick_count = 0;
    stall_left = 0;
    stall_mode = RX_OPEN;
    pat_cnt    = 0;
    paused     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: idle ticks, good and bad reads, writes, line reset
    run_op(swdhpe_pkg::FUNC_TICK, 1'b0, 1'b0, 2'd0, 32'd0, 1'b0, swdhpe_pkg::ACK_OK,
           32'd0, 1'b0);
    run_op(FUNC_SPARE, 1'b1, 1'b1, 2'd3, swdhpe_pkg::ALL_ONES, 1'b1, swdhpe_pkg::ACK_OK,
           32'd0, 1'b0);
    run_op(swdhpe_pkg::FUNC_XFER, 1'b0, 1'b1, 2'd0, swdhpe_pkg::ALL_ONES, 1'b0,
           swdhpe_pkg::ACK_OK, 32'd0, 1'b0);
    run_op(swdhpe_pkg::FUNC_XFER, 1'b1, 1'b1, 2'd3, 32'd0, 1'b1, swdhpe_pkg::ACK_OK,
           swdhpe_pkg::ALL_ONES, 1'b1);
    run_op(swdhpe_pkg::FUNC_XFER, 1'b1, 1'b1, 2'd1, 32'd0, 1'b0, ACK_WAIT,
           swdhpe_pkg::ALL_ONES, 1'b0);
    run_op(swdhpe_pkg::FUNC_XFER, 1'b0, 1'b1, 2'd2, 32'd0, 1'b0, ACK_NONE, 32'd0, 1'b0);
    run_op(swdhpe_pkg::FUNC_XFER, 1'b0, 1'b0, 2'd1, 32'd0, 1'b0, swdhpe_pkg::ACK_OK,
           32'd0, 1'b0);
    run_op(swdhpe_pkg::FUNC_XFER, 1'b1, 1'b0, 2'd2, swdhpe_pkg::ALL_ONES, 1'b1, ACK_FAULT,
           32'd0, 1'b0);
    run_op(swdhpe_pkg::FUNC_XFER, 1'b1, 1'b0, 2'd3, 32'h5A5A_C3C3, 1'b0, ACK_ZERO,
           32'd0, 1'b0);
    run_op(swdhpe_pkg::FUNC_LRST, 1'b0, 1'b0, 2'd0, 32'd0, 1'b0, swdhpe_pkg::ACK_OK,
           32'd0, 1'b0);
    drain_results();

    // random operations, mostly transfers with ok acknowledge
    random_end = tick_count + RANDOM_TICKS;
    while (tick_count < random_end) begin
      r = $urandom_range(0, 99);
      if (r < 72) f = swdhpe_pkg::FUNC_XFER;
      else if (r < 82) f = swdhpe_pkg::FUNC_LRST;
      else if (r < 91) f = swdhpe_pkg::FUNC_TICK;
      else f = FUNC_SPARE;
      ack = ($urandom_range(0, 99) < 75) ? swdhpe_pkg::ACK_OK : 3'($urandom_range(0, 7));
      run_op(f, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
             2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)), ack, $urandom,
             ($urandom_range(0, 99) < 25));
      if (!paused && tick_count > random_end - RANDOM_TICKS / 2) begin
        paused = 1'b1;
        drain_results();
      end
    end

    // wind down
    drain_results();
    repeat (4) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d result words never came", sb.pending()));
    if (sb.errors == 0) begin
      $display("swd_host_packet_engine_unit regression: pass");
    end else begin
      $display("swd_host_packet_engine_unit regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
design/swdhpe_pkg.sv
design/swdhpe_seq.sv
design/swd_host_packet_engine_unit.sv
tb/sv/swd_host_packet_engine_unit_tb.sv
